// ===== src/bpfm_pkg.sv =====
package bpfm_pkg;

  localparam int unsigned PoolSize = 16;
  localparam int unsigned FrameW = $clog2(PoolSize);
  localparam int unsigned CntW = FrameW + 1;
  localparam int unsigned PinW = 8;
  localparam logic [PinW-1:0] PinLimit = 8'd255;
  localparam logic [31:0] NoPage = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ModeFetch    = 3'd0,
    ModeUnpin    = 3'd1,
    ModeFlush    = 3'd2,
    ModeNew      = 3'd3,
    ModeDelete   = 3'd4,
    ModeFlushAll = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StRefused = 2'd1,
    StNoFrame = 2'd2,
    StPinLim  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OpNone  = 2'd0,
    OpWrite = 2'd1,
    OpRead  = 2'd2,
    OpDealloc = 2'd3
  } disk_op_e;

  // Per-frame command issued by the controller to one frame cell.
  typedef struct packed {
    logic        load;      // install a page, pin 1, clean
    logic [31:0] page;
    logic        clear;     // drop page, clean, pin 0
    logic        pin_inc;
    logic        pin_dec;
    logic        set_dirty;
    logic        clr_dirty;
  } cell_cmd_t;

  // Status reported by one frame cell.
  typedef struct packed {
    logic [31:0]     page;
    logic            dirty;
    logic [PinW-1:0] pin;
  } cell_stat_t;

  // Shift command for the LRU chain.
  typedef struct packed {
    logic              push;   // append frame at tail
    logic [FrameW-1:0] frame;
    logic              remove; // remove entry holding frame
  } lru_cmd_t;

endpackage

// ===== src/bpfm_frame_cell.sv =====
module bpfm_frame_cell
  import bpfm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_cmd_t  cmd_i,
  output cell_stat_t stat_o
);

  logic [31:0]     page_q;
  logic            dirty_q;
  logic [PinW-1:0] pin_q;

  // Frame state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q  <= NoPage;
      dirty_q <= 1'b0;
      pin_q   <= '0;
    end else begin
      if (cmd_i.clear) begin
        page_q  <= NoPage;
        dirty_q <= 1'b0;
        pin_q   <= '0;
      end else if (cmd_i.load) begin
        page_q  <= cmd_i.page;
        dirty_q <= 1'b0;
        pin_q   <= PinW'(1);
      end else begin
        if (cmd_i.pin_inc) pin_q <= pin_q + PinW'(1);
        if (cmd_i.pin_dec) pin_q <= pin_q - PinW'(1);
        if (cmd_i.clr_dirty) dirty_q <= 1'b0;
        else if (cmd_i.set_dirty) dirty_q <= 1'b1;
      end
    end
  end

  assign stat_o = '{page: page_q, dirty: dirty_q, pin: pin_q};

endmodule

// ===== src/bpfm_lru_cell.sv =====
module bpfm_lru_cell
  import bpfm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lru_cmd_t          cmd_i,
  input  logic              is_tail_i,    // this slot receives a push
  input  logic [FrameW-1:0] next_frame_i, // entry of the right neighbor
  input  logic              shift_in_i,   // a left-side entry was removed
  output logic [FrameW-1:0] frame_o,
  output logic              shift_out_o   // tell right neighbor to shift
);

  logic [FrameW-1:0] frame_q;
  logic              hit;

  assign hit = cmd_i.remove && (frame_q == cmd_i.frame);
  assign shift_out_o = shift_in_i || hit;
  assign frame_o = frame_q;

  // Entry moves one slot toward the head when an entry at or before it goes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (cmd_i.push && is_tail_i) begin
      frame_q <= cmd_i.frame;
    end else if (shift_out_o) begin
      frame_q <= next_frame_i;
    end
  end

endmodule

// ===== src/buffer_pool_frame_manager.sv =====
// Buffer pool frame manager for 16 page frames, least-recently-unpinned
// replacement. A request beat on s_axis is taken only while the manager is
// idle. It then passes through a frame lookup state and a decision state. Its
// result beat then waits on m_axis. A dirty eviction adds a second result
// beat. Flush-all sends one result beat per resident frame, one per cycle
// while m_axis is ready. Frames are held in a row of frame cells, and the LRU
// order in a row of cells that shift toward the head on a removal. Results
// carry tlast on the final beat of each request.
module buffer_pool_frame_manager
  import bpfm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // mode[2:0], page_id[34:3], dirty[35], new_page_id[66:36]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // status[1:0], frame[5:2], disk_op[7:6], disk_page[39:8]
  output logic        m_axis_tlast
);

  typedef enum logic [5:0] {
    SIdle   = 6'b000001,
    SLook   = 6'b000010,
    SExec   = 6'b000100,
    SOut    = 6'b001000,
    SScan   = 6'b010000,
    SOut2   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [2:0]  mode_q;
  logic [31:0] pid_q;
  logic        dirty_q;
  logic [30:0] npid_q;

  cell_cmd_t  ccmd [PoolSize];
  cell_stat_t cstat [PoolSize];

  // Frame cells.
  for (genvar g = 0; g < PoolSize; g++) begin : g_frame
    bpfm_frame_cell u_cell (.clk_i, .rst_ni, .cmd_i(ccmd[g]), .stat_o(cstat[g]));
  end

  // LRU chain.
  lru_cmd_t          lcmd;
  logic [FrameW-1:0] lfr [PoolSize];
  logic              lsh [PoolSize+1];
  logic [CntW-1:0]   lru_cnt_q;
  logic              in_lru;
  assign lsh[0] = 1'b0;
  for (genvar g = 0; g < PoolSize; g++) begin : g_lru
    logic [FrameW-1:0] nxt;
    logic              valid_in;
    if (g == PoolSize-1) begin : g_end
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = lfr[g+1];
    end
    lru_cmd_t c;
    assign valid_in = CntW'(g) < lru_cnt_q;
    always_comb begin
      c = lcmd;
      c.remove = lcmd.remove && valid_in;
    end
    bpfm_lru_cell u_lru (
      .clk_i, .rst_ni, .cmd_i(c), .is_tail_i(CntW'(g) == lru_cnt_q),
      .next_frame_i(nxt), .shift_in_i(lsh[g] && valid_in),
      .frame_o(lfr[g]), .shift_out_o(lsh[g+1])
    );
  end

  // A removal only shortens the chain when the frame is in it.
  always_comb begin
    in_lru = 1'b0;
    for (int i = 0; i < PoolSize; i++) begin
      if (CntW'(i) < lru_cnt_q && lfr[i] == lcmd.frame) in_lru = 1'b1;
    end
  end

  // Free stack.
  logic [FrameW-1:0] fstk_q [PoolSize];
  logic [CntW-1:0]   ftop_q;

  // Lookup result registered.
  logic              hit_q;
  logic [FrameW-1:0] hitf_q;
  logic              any_q;
  logic              hit_c;
  logic [FrameW-1:0] hitf_c;
  always_comb begin
    hit_c = 1'b0;
    hitf_c = '0;
    for (int i = PoolSize-1; i >= 0; i--) begin
      if (cstat[i].page == pid_q) begin
        hit_c = 1'b1;
        hitf_c = FrameW'(i);
      end
    end
    if (pid_q == NoPage) hit_c = 1'b0;
  end

  // Output register and pending second beat.
  logic [1:0]  ost_q;
  logic [FrameW-1:0] ofr_q;
  logic [1:0]  oop_q;
  logic [31:0] opg_q;
  logic        olast_q;
  logic [FrameW-1:0] f2_q;
  logic [1:0]  op2_q;
  logic [31:0] pg2_q;
  logic [FrameW-1:0] scan_q;
  logic [PoolSize-1:0] res_q;

  logic [FrameW-1:0] vict;
  logic              take_ok;
  logic              from_free;
  logic [PoolSize-1:0] resident;
  logic [FrameW-1:0] last_res;
  logic [FrameW-1:0] nxt_scan;
  logic              more;
  logic              m_fire;

  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign from_free = ftop_q != '0;
  assign take_ok = from_free || (lru_cnt_q != '0);
  assign vict = from_free ? fstk_q[FrameW'(ftop_q - CntW'(1))] : lfr[0];

  always_comb begin
    for (int i = 0; i < PoolSize; i++) resident[i] = cstat[i].page != NoPage;
  end

  // Next resident frame after scan_q and the highest resident frame.
  always_comb begin
    last_res = '0;
    nxt_scan = '0;
    more = 1'b0;
    for (int i = 0; i < PoolSize; i++) begin
      if (res_q[i]) last_res = FrameW'(i);
    end
    for (int i = PoolSize-1; i >= 0; i--) begin
      if (res_q[i] && FrameW'(i) > scan_q) begin
        nxt_scan = FrameW'(i);
        more = 1'b1;
      end
    end
  end

  assign s_axis_tready = state_q == SIdle;
  assign m_axis_tvalid = (state_q == SOut) || (state_q == SOut2) || (state_q == SScan);
  assign m_axis_tdata = {opg_q, oop_q, ofr_q, ost_q};
  assign m_axis_tlast = olast_q;

  // Control and state update.
  always_comb begin
    state_d = state_q;
    lcmd = '0;
    for (int i = 0; i < PoolSize; i++) ccmd[i] = '0;
    case (state_q)
      SIdle: if (s_axis_tvalid) state_d = SLook;
      SLook: state_d = SExec;
      SExec: begin
        state_d = SOut;
        case (mode_q)
          ModeFetch: begin
            if (pid_q != NoPage && hit_q) begin
              if (cstat[hitf_q].pin < PinLimit) begin
                ccmd[hitf_q].pin_inc = 1'b1;
                lcmd.remove = 1'b1;
                lcmd.frame = hitf_q;
              end
            end else if (pid_q != NoPage && take_ok) begin
              ccmd[vict].load = 1'b1;
              ccmd[vict].page = pid_q;
              lcmd.remove = !from_free;
              lcmd.frame = vict;
            end
          end
          ModeNew: if (take_ok) begin
            ccmd[vict].load = 1'b1;
            ccmd[vict].page = {1'b0, npid_q};
            lcmd.remove = !from_free;
            lcmd.frame = vict;
          end
          ModeUnpin: if (hit_q && cstat[hitf_q].pin != '0) begin
            ccmd[hitf_q].pin_dec = 1'b1;
            ccmd[hitf_q].set_dirty = dirty_q;
            lcmd.push = cstat[hitf_q].pin == PinW'(1);
            lcmd.frame = hitf_q;
          end
          ModeFlush: if (hit_q) ccmd[hitf_q].clr_dirty = 1'b1;
          ModeDelete: if (hit_q && cstat[hitf_q].pin == '0) begin
            ccmd[hitf_q].clear = 1'b1;
            lcmd.remove = 1'b1;
            lcmd.frame = hitf_q;
          end
          ModeFlushAll: if (any_q) state_d = SScan;
          default: ;
        endcase
      end
      SOut: if (m_fire) state_d = (op2_q != OpNone || f2_q != '0 || pg2_q != '0)
                                  ? SOut2 : SIdle;
      SOut2: if (m_fire) state_d = SIdle;
      SScan: if (m_fire) begin
        ccmd[scan_q].clr_dirty = 1'b1;
        if (!more) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ftop_q <= CntW'(PoolSize);
      lru_cnt_q <= '0;
      for (int i = 0; i < PoolSize; i++) fstk_q[i] <= FrameW'(i);
    end else begin
      state_q <= state_d;
      if (state_q == SExec) begin
        if (lcmd.push) lru_cnt_q <= lru_cnt_q + CntW'(1);
        else if (lcmd.remove && in_lru) lru_cnt_q <= lru_cnt_q - CntW'(1);
        if ((mode_q == ModeFetch && !(hit_q) && pid_q != NoPage) || mode_q == ModeNew) begin
          if (from_free) ftop_q <= ftop_q - CntW'(1);
        end
        if (mode_q == ModeDelete && hit_q && cstat[hitf_q].pin == '0 &&
            ftop_q < CntW'(PoolSize)) begin
          fstk_q[FrameW'(ftop_q)] <= hitf_q;
          ftop_q <= ftop_q + CntW'(1);
        end
      end
    end
  end

  // Payload path.
  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        mode_q  <= s_axis_tdata[2:0];
        pid_q   <= s_axis_tdata[34:3];
        dirty_q <= s_axis_tdata[35];
        npid_q  <= s_axis_tdata[66:36];
      end
      SLook: begin
        hit_q  <= hit_c;
        hitf_q <= hitf_c;
        any_q  <= |resident;
        res_q  <= resident;
      end
      SExec: begin
        ost_q <= StOk; ofr_q <= '0; oop_q <= OpNone; opg_q <= NoPage; olast_q <= 1'b1;
        op2_q <= OpNone; f2_q <= '0; pg2_q <= '0;
        case (mode_q)
          ModeFetch, ModeNew: begin
            if (mode_q == ModeFetch && pid_q == NoPage) ost_q <= StRefused;
            else if (mode_q == ModeFetch && hit_q) begin
              ofr_q <= hitf_q;
              if (cstat[hitf_q].pin >= PinLimit) ost_q <= StPinLim;
            end else if (!take_ok) ost_q <= StNoFrame;
            else if (!from_free && cstat[vict].dirty) begin
              oop_q <= OpWrite; ofr_q <= vict; opg_q <= cstat[vict].page; olast_q <= 1'b0;
              f2_q <= vict; pg2_q <= (mode_q == ModeNew) ? {1'b0, npid_q} : pid_q;
              op2_q <= (mode_q == ModeNew) ? OpWrite : OpRead;
            end else begin
              ofr_q <= vict;
              oop_q <= (mode_q == ModeNew) ? OpWrite : OpRead;
              opg_q <= (mode_q == ModeNew) ? {1'b0, npid_q} : pid_q;
            end
          end
          ModeUnpin: begin
            if (!hit_q) ost_q <= StRefused;
            else begin
              ofr_q <= hitf_q;
              if (cstat[hitf_q].pin == '0) ost_q <= StRefused;
            end
          end
          ModeFlush: begin
            if (!hit_q) ost_q <= StRefused;
            else begin ofr_q <= hitf_q; oop_q <= OpWrite; opg_q <= pid_q; end
          end
          ModeDelete: begin
            if (hit_q) begin
              ofr_q <= hitf_q;
              if (cstat[hitf_q].pin != '0) ost_q <= StRefused;
              else begin oop_q <= OpDealloc; opg_q <= pid_q; end
            end
          end
          ModeFlushAll: begin
            if (any_q) begin
              for (int i = PoolSize-1; i >= 0; i--) begin
                if (res_q[i]) begin
                  scan_q <= FrameW'(i); ofr_q <= FrameW'(i);
                  opg_q <= cstat[i].page;
                  olast_q <= FrameW'(i) == last_res;
                end
              end
              oop_q <= OpWrite;
            end
          end
          default: ost_q <= StRefused;
        endcase
      end
      SOut: if (m_fire) begin
        ost_q <= StOk; ofr_q <= f2_q; oop_q <= op2_q; opg_q <= pg2_q; olast_q <= 1'b1;
      end
      SScan: if (m_fire && more) begin
        scan_q <= nxt_scan; ofr_q <= nxt_scan;
        opg_q <= cstat[nxt_scan].page;
        olast_q <= nxt_scan == last_res;
      end
      default: ;
    endcase
  end

endmodule
